// ===== hw/rtl/rigid_body_aabb_step_macros.svh =====
// ----------------------------------------------------------------------------
// Rigid body step: assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_AABB_STEP_MACROS_SVH
`define RIGID_BODY_AABB_STEP_MACROS_SVH

`ifndef NO_ASSERTIONS

// When the condition holds, the consequence must hold in the same cycle.
`define RBAS_ASSERT_IMP(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("rbas: same-cycle check failed");

// When the condition holds, the consequence must hold in the following cycle.
`define RBAS_ASSERT_NXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("rbas: next-cycle check failed");

`else

`define RBAS_ASSERT_IMP(lbl, clk, rst, cond, cons)
`define RBAS_ASSERT_NXT(lbl, clk, rst, cond, cons)

`endif

`endif

// ===== hw/rtl/rbas_pkg.sv =====
// ----------------------------------------------------------------------------
// Rigid body step package
// Request and register codes, multiplier operation codes, unit status type
// and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package rbas_pkg;

  // Request codes carried in req_type.
  localparam int REQ_W = 3;
  localparam logic [REQ_W-1:0] REQ_FORCE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BOX   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SETV  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PLACE = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS = 1'd1;

  // Operations issued to the shared multiplier.
  localparam int MOP_W = 3;
  localparam logic [MOP_W-1:0] MOP_GRAV = 3'd0;
  localparam logic [MOP_W-1:0] MOP_AX   = 3'd1;
  localparam logic [MOP_W-1:0] MOP_AY   = 3'd2;
  localparam logic [MOP_W-1:0] MOP_VX   = 3'd3;
  localparam logic [MOP_W-1:0] MOP_VY   = 3'd4;
  localparam logic [MOP_W-1:0] MOP_FRIC = 3'd5;

  // Widths of the multiplier operands and of its shifted result.
  localparam int OPND_W = 33;
  localparam int PROD_W = 66;
  localparam int WIDE_W = 68;

  // Status that each arithmetic unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -68'sh0_0000_0000_8000_0000;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = signed'(v[31:0]);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rbas_if.sv =====
// ----------------------------------------------------------------------------
// Rigid body step channels
// Valid/ready channels for request words, result words and register writes.
// ----------------------------------------------------------------------------

// Request channel.
interface rbas_item_if;
  logic                             valid;
  logic                             ready;
  logic [rbas_pkg::REQ_W-1:0]       req_type;
  logic signed [31:0]               vec_x;
  logic signed [31:0]               vec_y;
  logic [30:0]                      time_step;
  logic signed [15:0]               box_x;
  logic signed [15:0]               box_y;
  logic [14:0]                      box_w;
  logic [14:0]                      box_h;
  logic                             clear_motion;

  modport source (output valid, req_type, vec_x, vec_y, time_step, box_x, box_y,
                  box_w, box_h, clear_motion, input ready);
  modport sink (input valid, req_type, vec_x, vec_y, time_step, box_x, box_y,
                box_w, box_h, clear_motion, output ready);
endinterface

// Result channel.
interface rbas_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               hit;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, hit, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, hit, output ready);
endinterface

// Register write channel.
interface rbas_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbas_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/rbas_div.sv =====
// ----------------------------------------------------------------------------
// Rigid body step divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbas_div #(
  parameter int NUM_W = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_W-1:0]       num,
  input  logic [30:0]            den,
  output rbas_pkg::unit_stat_t   stat,
  output logic [NUM_W-1:0]       quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [31:0]      rem;
  logic [31:0]      trial;
  logic             ge;

  // Bring down the next numerator bit and try the subtraction.
  always_comb begin
    trial = {rem[30:0], quo[NUM_W-1]};
    ge    = (trial >= {1'b0, den});
  end

  // Control: count down one step per quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator register fills with quotient bits from the right.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, den}) : trial;
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/rbas_mul.sv =====
// ----------------------------------------------------------------------------
// Rigid body step multiplier
// Two-stage signed multiplier with a fixed-point shift that rounds toward zero.
// ----------------------------------------------------------------------------
module rbas_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  go,
  input  logic                                  wide,
  input  logic signed [rbas_pkg::OPND_W-1:0]    a,
  input  logic signed [rbas_pkg::OPND_W-1:0]    b,
  output rbas_pkg::unit_stat_t                  stat,
  output logic signed [rbas_pkg::PROD_W-1:0]    res
);

  localparam int PW = rbas_pkg::PROD_W;
  localparam logic [PW-1:0] MASK_N = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic [PW-1:0] MASK_W = (PW'(1) << (2 * FRAC_BITS)) - PW'(1);

  logic                 v1;
  logic                 v2;
  logic                 wide1;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        bias;
  logic signed [PW-1:0] biased;
  logic signed [PW-1:0] shifted;

  // Negative products get a bias so the arithmetic shift truncates toward zero.
  always_comb begin
    bias    = prod[PW-1] ? (wide1 ? MASK_W : MASK_N) : '0;
    biased  = prod + signed'(bias);
    shifted = wide1 ? (biased >>> (2 * FRAC_BITS)) : (biased >>> FRAC_BITS);
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= go;
      v2 <= v1;
    end
  end

  // Product register, then the shifted result register.
  always_ff @(posedge clk) begin
    if (go) begin
      prod  <= PW'(a) * PW'(b);
      wide1 <= wide;
    end
    if (v1) begin
      res <= shifted;
    end
  end

  assign stat.busy = v1;
  assign stat.done = v2;

endmodule

// ===== hw/rtl/rigid_body_aabb_step.sv =====
// ----------------------------------------------------------------------------
// Rigid body step with box collision
// Keeps one body (box, velocity, accumulated acceleration) and updates it for
// force, tick, box test, set-velocity and place request words.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request words; taken only while the sequencer is idle.
//   result : one result word per request, held in an output register until
//            the receiver takes it; the next request may be accepted while
//            a result still waits.
//   cfg    : register writes (gravity, body_mass), always ready; write only
//            while no request is in flight.
// Steps from accept to result valid:
//   force        : the serial divider runs once per axis, at one bit per cycle.
//   tick         : five passes through the shared two-stage multiplier.
//   box test     : the overlap step; on overlap also a push step, and for a
//                  vertical (floor) push a pass through the multiplier.
//   set, place   : applied at dispatch, then the result.
// Reset clears the body state, gravity to zero and mass to 1.0. When the
// receiver stalls, a finished step waits in the sequencer until the output
// register frees, and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
`include "rigid_body_aabb_step_macros.svh"

module rigid_body_aabb_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  rbas_cfg_if.sink             cfg,
  rbas_item_if.sink            item,
  rbas_result_if.source        result
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int OW    = rbas_pkg::OPND_W;
  localparam int PW    = rbas_pkg::PROD_W;
  localparam int XW    = rbas_pkg::WIDE_W;
  localparam logic [30:0] MASS_ONE = 31'(1) << FRAC_BITS;
  localparam logic signed [OW-1:0] LIM = signed'(OW'(2) << FRAC_BITS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_MWAIT = 3'd4;
  localparam logic [2:0] S_BOXA  = 3'd5;
  localparam logic [2:0] S_BOXB  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;

  // Configuration registers.
  logic signed [31:0] gravity;
  logic [30:0]        body_mass;

  // Body state.
  logic signed [15:0] body_x;
  logic signed [15:0] body_y;
  logic [14:0]        body_w;
  logic [14:0]        body_h;
  logic signed [31:0] speed_x;
  logic signed [31:0] speed_y;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;

  // Captured request word.
  logic [rbas_pkg::REQ_W-1:0] rq_type;
  logic signed [31:0]         rq_vx;
  logic signed [31:0]         rq_vy;
  logic [30:0]                rq_dt;
  logic signed [15:0]         rq_bx;
  logic signed [15:0]         rq_by;
  logic [14:0]                rq_bw;
  logic [14:0]                rq_bh;
  logic                       rq_clr;

  // Working registers.
  logic                        hit;
  logic [rbas_pkg::MOP_W-1:0]  mop;
  logic                        div_y;
  logic                        div_neg;
  logic signed [17:0]          dx;
  logic signed [17:0]          dy;
  logic [14:0]                 hx;
  logic [14:0]                 hy;

  // Output register.
  logic               res_valid;
  logic signed [15:0] o_pos_x;
  logic signed [15:0] o_pos_y;
  logic signed [31:0] o_vel_x;
  logic signed [31:0] o_vel_y;
  logic               o_hit;

  // -------------------------------------------------------------------------
  // Shared divider.
  // -------------------------------------------------------------------------
  rbas_pkg::unit_stat_t div_stat;
  logic                 div_go;
  logic signed [31:0]   div_sel;
  logic [31:0]          div_abs;
  logic [NUM_W-1:0]     div_num;
  logic [30:0]          div_den;
  logic [NUM_W-1:0]     div_quo;

  // Start on a force request, then again for the y axis after x finishes.
  always_comb begin
    div_go  = ((state == S_DISP) && (rq_type == rbas_pkg::REQ_FORCE)) ||
              ((state == S_DIV) && div_stat.done && !div_y);
    div_sel = (state == S_DIV) ? rq_vy : rq_vx;
    div_abs = div_sel[31] ? 32'(-div_sel) : 32'(div_sel);
    div_num = {div_abs, {FRAC_BITS{1'b0}}};
    div_den = (body_mass == '0) ? 31'(1) : body_mass;
  end

  rbas_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // Signed, saturated quotient added into the selected acceleration.
  logic signed [33:0] q_mag;
  logic signed [33:0] q_val;
  logic signed [31:0] q_sat;
  logic signed [31:0] acc_old;
  logic signed [31:0] acc_new;

  always_comb begin
    q_mag   = (|div_quo[NUM_W-1:32]) ? 34'sh1_0000_0000 : signed'({2'b00, div_quo[31:0]});
    q_val   = div_neg ? -q_mag : q_mag;
    q_sat   = rbas_pkg::sat32(XW'(q_val));
    acc_old = div_y ? accel_y : accel_x;
    acc_new = rbas_pkg::sat32(XW'(acc_old) + XW'(q_sat));
  end

  // -------------------------------------------------------------------------
  // Shared multiplier.
  // -------------------------------------------------------------------------
  rbas_pkg::unit_stat_t  mul_stat;
  logic                  mul_go;
  logic                  mul_wide;
  logic signed [OW-1:0]  mul_a;
  logic signed [OW-1:0]  mul_b;
  logic signed [PW-1:0]  mq;

  // Operand selection by operation code.
  always_comb begin
    mul_go   = (state == S_MUL);
    mul_wide = (mop == rbas_pkg::MOP_VX) || (mop == rbas_pkg::MOP_VY);
    mul_b    = signed'({2'b00, rq_dt});
    case (mop)
      rbas_pkg::MOP_GRAV: mul_a = OW'(gravity);
      rbas_pkg::MOP_AX:   mul_a = OW'(accel_x);
      rbas_pkg::MOP_AY:   mul_a = OW'(accel_y);
      rbas_pkg::MOP_VX:   mul_a = OW'(speed_x);
      rbas_pkg::MOP_VY:   mul_a = OW'(speed_y);
      rbas_pkg::MOP_FRIC: begin
        mul_a = signed'({2'b00, body_mass});
        mul_b = OW'(gravity);
      end
      default:            mul_a = '0;
    endcase
  end

  rbas_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .wide (mul_wide),
    .a    (mul_a),
    .b    (mul_b),
    .stat (mul_stat),
    .res  (mq)
  );

  // Velocity sums with the scaled product.
  logic signed [31:0] sum_vx;
  logic signed [31:0] sum_vy;

  always_comb begin
    sum_vx = rbas_pkg::sat32(XW'(speed_x) + XW'(mq));
    sum_vy = rbas_pkg::sat32(XW'(speed_y) + XW'(mq));
  end

  // Floor friction toward zero, with a dead band around zero.
  logic signed [31:0] fr;
  logic signed [31:0] fr_sub;
  logic signed [31:0] fr_add;
  logic signed [31:0] fric_vx;

  always_comb begin
    fr     = rbas_pkg::sat32(XW'(mq));
    fr_sub = rbas_pkg::sat32(XW'(speed_x) - XW'(fr));
    fr_add = rbas_pkg::sat32(XW'(speed_x) + XW'(fr));
    if ((OW'(speed_x) >= -LIM) && (OW'(speed_x) <= LIM)) begin
      fric_vx = '0;
    end else if (!speed_x[31]) begin
      fric_vx = fr_sub[31] ? 32'sd0 : fr_sub;
    end else begin
      fric_vx = (!fr_add[31] && (fr_add != 32'sd0)) ? 32'sd0 : fr_add;
    end
  end

  // -------------------------------------------------------------------------
  // Box overlap test and push-out geometry.
  // -------------------------------------------------------------------------
  logic signed [17:0] own_x;
  logic signed [17:0] own_y;
  logic signed [17:0] own_xe;
  logic signed [17:0] own_ye;
  logic signed [17:0] oth_x;
  logic signed [17:0] oth_y;
  logic signed [17:0] oth_xe;
  logic signed [17:0] oth_ye;
  logic               ov;
  logic signed [17:0] dx_n;
  logic signed [17:0] dy_n;

  // First step: overlap and center offsets.
  always_comb begin
    own_x  = 18'(body_x);
    own_y  = 18'(body_y);
    oth_x  = 18'(rq_bx);
    oth_y  = 18'(rq_by);
    own_xe = own_x + signed'(18'(body_w));
    own_ye = own_y + signed'(18'(body_h));
    oth_xe = oth_x + signed'(18'(rq_bw));
    oth_ye = oth_y + signed'(18'(rq_bh));
    ov     = (body_w != '0) && (body_h != '0) && (rq_bw != '0) && (rq_bh != '0) &&
             (own_x < oth_xe) && (oth_x < own_xe) &&
             (own_y < oth_ye) && (oth_y < own_ye);
    dx_n   = own_x + signed'(18'(body_w >> 1)) - oth_x - signed'(18'(rq_bw >> 1));
    dy_n   = own_y + signed'(18'(body_h >> 1)) - oth_y - signed'(18'(rq_bh >> 1));
  end

  logic signed [17:0] adx;
  logic signed [17:0] ady;
  logic signed [18:0] tx;
  logic signed [18:0] ty;
  logic signed [18:0] tx_r;
  logic signed [18:0] ty_r;
  logic signed [18:0] ix;
  logic signed [18:0] iy;
  logic               dx_pos;
  logic               dy_pos;
  logic signed [15:0] push_x;
  logic signed [15:0] push_y;

  // Second step: penetration depths (halved toward zero) and push targets.
  always_comb begin
    adx    = dx[17] ? -dx : dx;
    ady    = dy[17] ? -dy : dy;
    tx     = 19'(adx) - signed'(19'(hx));
    ty     = 19'(ady) - signed'(19'(hy));
    tx_r   = tx + signed'({18'b0, tx[18]});
    ty_r   = ty + signed'({18'b0, ty[18]});
    ix     = tx_r >>> 1;
    iy     = ty_r >>> 1;
    dx_pos = !dx[17] && (dx != '0);
    dy_pos = !dy[17] && (dy != '0);
    push_x = dx_pos ? (rq_bx + signed'(16'(rq_bw))) : (rq_bx - signed'(16'(body_w)));
    push_y = dy_pos ? (rq_by + signed'(16'(rq_bh))) : (rq_by - signed'(16'(body_h)));
  end

  // -------------------------------------------------------------------------
  // Configuration writes.
  // -------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity   <= '0;
      body_mass <= MASS_ONE;
    end else if (cfg.valid) begin
      case (cfg.index)
        rbas_pkg::REG_GRAVITY:   gravity <= signed'(cfg.wdata);
        rbas_pkg::REG_BODY_MASS: body_mass <= cfg.wdata[30:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Request capture.
  // -------------------------------------------------------------------------
  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      rq_type <= item.req_type;
      rq_vx   <= item.vec_x;
      rq_vy   <= item.vec_y;
      rq_dt   <= item.time_step;
      rq_bx   <= item.box_x;
      rq_by   <= item.box_y;
      rq_bw   <= item.box_w;
      rq_bh   <= item.box_h;
      rq_clr  <= item.clear_motion;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer and body state.
  // -------------------------------------------------------------------------
  logic out_free;
  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      body_x    <= '0;
      body_y    <= '0;
      body_w    <= '0;
      body_h    <= '0;
      speed_x   <= '0;
      speed_y   <= '0;
      accel_x   <= '0;
      accel_y   <= '0;
      hit       <= 1'b0;
      mop       <= rbas_pkg::MOP_GRAV;
      div_y     <= 1'b0;
      div_neg   <= 1'b0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          hit <= 1'b0;
          case (rq_type)
            rbas_pkg::REQ_FORCE: begin
              div_y   <= 1'b0;
              div_neg <= rq_vx[31];
              state   <= S_DIV;
            end
            rbas_pkg::REQ_TICK: begin
              mop   <= rbas_pkg::MOP_GRAV;
              state <= S_MUL;
            end
            rbas_pkg::REQ_BOX: begin
              state <= S_BOXA;
            end
            rbas_pkg::REQ_SETV: begin
              speed_x <= rq_vx;
              speed_y <= rq_vy;
              state   <= S_DONE;
            end
            rbas_pkg::REQ_PLACE: begin
              body_x <= rq_bx;
              body_y <= rq_by;
              body_w <= rq_bw;
              body_h <= rq_bh;
              if (rq_clr) begin
                speed_x <= '0;
                speed_y <= '0;
                accel_x <= '0;
                accel_y <= '0;
              end
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (div_y) begin
              accel_y <= acc_new;
              state   <= S_DONE;
            end else begin
              accel_x <= acc_new;
              div_y   <= 1'b1;
              div_neg <= rq_vy[31];
            end
          end
        end
        S_MUL: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_stat.done) begin
            case (mop)
              rbas_pkg::MOP_GRAV: begin
                speed_y <= sum_vy;
                mop     <= rbas_pkg::MOP_AX;
                state   <= S_MUL;
              end
              rbas_pkg::MOP_AX: begin
                speed_x <= sum_vx;
                mop     <= rbas_pkg::MOP_AY;
                state   <= S_MUL;
              end
              rbas_pkg::MOP_AY: begin
                speed_y <= sum_vy;
                mop     <= rbas_pkg::MOP_VX;
                state   <= S_MUL;
              end
              rbas_pkg::MOP_VX: begin
                body_x <= body_x + signed'(mq[15:0]);
                mop    <= rbas_pkg::MOP_VY;
                state  <= S_MUL;
              end
              rbas_pkg::MOP_VY: begin
                body_y  <= body_y + signed'(mq[15:0]);
                accel_x <= '0;
                accel_y <= '0;
                state   <= S_DONE;
              end
              rbas_pkg::MOP_FRIC: begin
                speed_y <= '0;
                speed_x <= fric_vx;
                body_y  <= push_y;
                state   <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_BOXA: begin
          hit   <= ov;
          dx    <= dx_n;
          dy    <= dy_n;
          hx    <= 15'((16'(body_w) + 16'(rq_bw)) >> 1);
          hy    <= 15'((16'(body_h) + 16'(rq_bh)) >> 1);
          state <= ov ? S_BOXB : S_DONE;
        end
        S_BOXB: begin
          if (ix > iy) begin
            // Horizontal push: stop along x and move beside the other box.
            speed_x <= '0;
            body_x  <= push_x;
            state   <= S_DONE;
          end else begin
            // Vertical push: friction needs mass times gravity first.
            mop   <= rbas_pkg::MOP_FRIC;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result word payload, loaded when the step finishes.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      o_pos_x <= body_x;
      o_pos_y <= body_y;
      o_vel_x <= speed_x;
      o_vel_y <= speed_y;
      o_hit   <= hit;
    end
  end

  assign result.valid = res_valid;
  assign result.pos_x = o_pos_x;
  assign result.pos_y = o_pos_y;
  assign result.vel_x = o_vel_x;
  assign result.vel_y = o_vel_y;
  assign result.hit   = o_hit;

  // -------------------------------------------------------------------------
  // Checks.
  // -------------------------------------------------------------------------
  `RBAS_ASSERT_NXT(a_accept_dispatch, clk, rst, item.valid && item.ready, state == S_DISP)
  `RBAS_ASSERT_IMP(a_div_done_state, clk, rst, div_stat.done, state == S_DIV)
  `RBAS_ASSERT_IMP(a_mul_done_state, clk, rst, mul_stat.done, state == S_MWAIT)
  `RBAS_ASSERT_IMP(a_units_exclusive, clk, rst, div_stat.busy, !mul_stat.busy)
  `RBAS_ASSERT_IMP(a_hit_only_box, clk, rst, (state == S_DONE) && hit, rq_type == rbas_pkg::REQ_BOX)

endmodule
